@@ sv/rcn_pkg.sv @@
// ----------------------------------------------------------------------------
// rcn_pkg: shared definitions for the RC channel normaliser
// Operation codes, the serial unit status bundle and fixed sizes.
// ----------------------------------------------------------------------------
package rcn_pkg;

  // Default pulse width resolution in bits (range 8 to 16)
  localparam int PW_BITS_DEF = 16;

  // Steps of the serial multiplier and divider, equal to the scale width
  localparam int SER_STEPS = 32;
  localparam int CNT_BITS  = $clog2(SER_STEPS);

  // 2^31, the numerator of the reciprocal scale
  localparam logic [SER_STEPS-1:0] RECIP_NUM = {1'b1, {(SER_STEPS-1){1'b0}}};

  // Deadzone register
  localparam int                DZ_BITS  = 15;
  localparam logic [DZ_BITS-1:0] DZ_RESET = 15'd1638;

  // Request operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_BOUNDS = 2'd1;
  localparam logic [1:0] OP_CENTER = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } rcn_stat_t;

endpackage

@@ sv/rcn_ser_mul.sv @@
// ----------------------------------------------------------------------------
// rcn_ser_mul: bit-serial shift-and-add multiplier
// Multiplies a WIDTH_BITS magnitude by a 32-bit scale, one scale bit a cycle.
// ----------------------------------------------------------------------------
module rcn_ser_mul #(
  parameter int WIDTH_BITS = rcn_pkg::PW_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [WIDTH_BITS-1:0]                  mag,
  input  logic [rcn_pkg::SER_STEPS-1:0]          scale,
  output logic [WIDTH_BITS+rcn_pkg::SER_STEPS-1:0] prod,
  output rcn_pkg::rcn_stat_t                     stat
);
  import rcn_pkg::*;

  localparam int PW = WIDTH_BITS + SER_STEPS;

  logic [PW-1:0]         prod_r, prod_nxt;
  logic [WIDTH_BITS-1:0] mag_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r, done_r;
  logic [WIDTH_BITS:0]   sum;

  // Add the multiplicand into the upper part when the next scale bit is set
  assign sum      = {1'b0, prod_r[PW-1:SER_STEPS]} +
                    (prod_r[0] ? {1'b0, mag_r} : {(WIDTH_BITS+1){1'b0}});
  assign prod_nxt = {sum, prod_r[SER_STEPS-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(SER_STEPS-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= mag;
      prod_r <= {{WIDTH_BITS{1'b0}}, scale};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod      = prod_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ sv/rcn_ser_div.sv @@
// ----------------------------------------------------------------------------
// rcn_ser_div: bit-serial restoring divider
// Divides 2^31 by a nonzero WIDTH_BITS offset, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rcn_ser_div #(
  parameter int WIDTH_BITS = rcn_pkg::PW_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [WIDTH_BITS-1:0]         divisor,
  output logic [rcn_pkg::SER_STEPS-1:0] quot,
  output rcn_pkg::rcn_stat_t            stat
);
  import rcn_pkg::*;

  logic [SER_STEPS-1:0]  quot_r;
  logic [WIDTH_BITS-1:0] rem_r, dvs_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r, done_r;
  logic [WIDTH_BITS:0]   trial, diff;
  logic                  fits;

  // Shift in the next numerator bit and try the subtraction
  assign trial = {rem_r, quot_r[SER_STEPS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(SER_STEPS-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r  <= divisor;
      rem_r  <= '0;
      quot_r <= RECIP_NUM;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[WIDTH_BITS-1:0] : trial[WIDTH_BITS-1:0];
      quot_r <= {quot_r[SER_STEPS-2:0], fits};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ sv/rc_channel_normalizer.sv @@
// ----------------------------------------------------------------------------
// rc_channel_normalizer: calibration and normalisation of one RC channel
// Clamps, centres and scales pulse widths into Q1.15 stick values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request carries an op and a
//   pulse width. A sample request gives one result; bounds, centre and clear
//   requests update the calibration and give none.
//   Result channel (out_valid / out_stall): raw width, normalised value and
//   a valid flag, held in an output register until the receiver takes it.
//   Configuration: cfg_wr_en writes the deadzone half-width; write it only
//   while no request is in flight.
// Sequencing:
//   A sample request passes from acceptance to out_valid through these steps:
//   clamp and centre, the bit-serial multiplier (one scale bit per cycle),
//   its done flag, then deadzone, saturation and the output register, where
//   it waits while that register is full. Samples run one at a time.
//   A centre request runs the 32-step serial divider for the reciprocal
//   scale when the largest offset is positive. Bounds and clear requests
//   apply on acceptance. A lost-signal sample (width 0) skips the multiplier.
// Reset: bounds, centre and scale clear to zero, deadzone returns to 1638.
// Stall: a stalled result holds; the block still accepts one further
// sample request and parks its result until the output register frees up.
// ----------------------------------------------------------------------------
module rc_channel_normalizer #(
  parameter int WIDTH_BITS = rcn_pkg::PW_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [15:0]                 in_pulse_width,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_raw_width,
  output logic signed [15:0]          out_norm_value,
  output logic                        out_valid_res,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [rcn_pkg::DZ_BITS-1:0] cfg_wr_data
);
  import rcn_pkg::*;

  localparam int W  = WIDTH_BITS;
  localparam int PW = W + SER_STEPS;
  localparam int MW = W + 16;          // scaled magnitude after the >> 16

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RES  = 3'd3;
  localparam logic [2:0] ST_OFS  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [DZ_BITS-1:0]   deadzone_r;
  logic [W-1:0]         lower_r, upper_r, center_r;
  logic [SER_STEPS-1:0] recip_r;

  // Request being worked on
  logic [W-1:0]         w_r;
  logic                 lost_r;
  logic                 neg_r;

  // Output register
  logic                 out_valid_r;
  logic [15:0]          out_raw_r;
  logic [15:0]          out_norm_r;
  logic                 out_vres_r;

  logic                 in_acc, out_take, out_free;
  logic [W-1:0]         w_in;

  // Serial units
  logic                 mul_start, div_start;
  logic [W-1:0]         mul_mag;
  logic [PW-1:0]        mul_prod;
  logic [SER_STEPS-1:0] div_quot;
  rcn_stat_t            mul_stat, div_stat;

  // Sample front end
  logic [W-1:0]         clamped;
  logic [W:0]           centred;

  // Offset for the reciprocal
  logic signed [W:0]    off_a, off_b, off_max;
  logic                 off_bad;

  // Deadzone and saturation
  logic [MW-1:0]        mag_scaled, mag_dz;
  logic                 in_dz, sat;
  logic [15:0]          norm_val;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign w_in      = in_pulse_width[W-1:0];

  // Clamp: lower test first, then upper
  always_comb begin
    if (w_r < lower_r) begin
      clamped = lower_r;
    end else if (w_r > upper_r) begin
      clamped = upper_r;
    end else begin
      clamped = w_r;
    end
    centred = {1'b0, clamped} - {1'b0, center_r};
    mul_mag = centred[W] ? W'(-centred) : centred[W-1:0];
  end

  // Largest offset from the centre, signed
  assign off_a   = $signed({1'b0, center_r}) - $signed({1'b0, lower_r});
  assign off_b   = $signed({1'b0, upper_r}) - $signed({1'b0, center_r});
  assign off_max = (off_a > off_b) ? off_a : off_b;
  assign off_bad = off_max[W] || (off_max == '0);

  // Drop the 16 fraction bits, remove the deadzone, saturate
  always_comb begin
    mag_scaled = mul_prod[PW-1:16];
    mag_dz     = mag_scaled - MW'(deadzone_r);
    in_dz      = mag_scaled <= MW'(deadzone_r);
    sat        = |mag_dz[MW-1:15];
    if (in_dz) begin
      norm_val = 16'h0000;
    end else if (neg_r) begin
      norm_val = sat ? 16'h8000 : (~mag_dz[15:0] + 16'd1);
    end else begin
      norm_val = sat ? 16'h7FFF : mag_dz[15:0];
    end
  end

  assign mul_start = (state_r == ST_PREP);
  assign div_start = (state_r == ST_OFS) && !off_bad;

  rcn_ser_mul #(.WIDTH_BITS(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mag   (mul_mag),
    .scale (recip_r),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  rcn_ser_div #(.WIDTH_BITS(W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (off_max[W-1:0]),
    .quot    (div_quot),
    .stat    (div_stat)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_op == OP_SAMPLE) begin
          state_nxt = (w_in == '0) ? ST_RES : ST_PREP;
        end else if (in_acc && in_op == OP_CENTER) begin
          state_nxt = ST_OFS;
        end
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_stat.done) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OFS: state_nxt = off_bad ? ST_IDLE : ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      deadzone_r  <= DZ_RESET;
      lower_r     <= '0;
      upper_r     <= '0;
      center_r    <= '0;
      recip_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        deadzone_r <= cfg_wr_data;
      end
      if (in_acc) begin
        unique case (in_op)
          OP_SAMPLE: ;
          OP_BOUNDS: begin
            if (upper_r == '0 || w_in > upper_r) begin
              upper_r <= w_in;
            end
            if (lower_r == '0 || w_in < lower_r) begin
              lower_r <= w_in;
            end
          end
          OP_CENTER: center_r <= w_in;
          OP_CLEAR: begin
            lower_r <= '0;
            upper_r <= '0;
          end
          default: ;
        endcase
      end
      // Store the new scale, or zero when the offset is not positive
      if (state_r == ST_OFS && off_bad) begin
        recip_r <= '0;
      end
      if (state_r == ST_DIV && div_stat.done) begin
        recip_r <= div_quot;
      end
      // Output handshake: drop on take, raise when a result lands
      if (state_r == ST_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_SAMPLE) begin
      w_r    <= w_in;
      lost_r <= (w_in == '0);
    end
    if (state_r == ST_PREP) begin
      neg_r <= centred[W];
    end
    if (state_r == ST_RES && out_free) begin
      if (lost_r) begin
        out_raw_r  <= 16'(center_r);
        out_norm_r <= 16'h0000;
        out_vres_r <= 1'b0;
      end else begin
        out_raw_r  <= 16'(w_r);
        out_norm_r <= norm_val;
        out_vres_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_raw_width  = out_raw_r;
  assign out_norm_value = $signed(out_norm_r);
  assign out_valid_res  = out_vres_r;

  // The multiplier runs for the whole of the multiply phase
  a_mul_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (mul_stat.busy || mul_stat.done))
    else $error("multiplier idle during multiply phase");

  // Unit completions only land in their own phase
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide phase");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == ST_MUL))
    else $error("multiplier finished outside multiply phase");

  // A lost signal always reports a zero value
  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_norm_value == 16'sd0))
    else $error("lost-signal result with nonzero value");

endmodule

@@ tb/sv/tb_rc_channel_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_channel_normalizer: self-checking bench for the RC channel normaliser
// Drives sample, bounds, centre and clear requests, first from a short
// directed table and then as random calibration sessions. Each sample result
// is checked against a cycle-free model of the calibration state, through
// phases of varied deadzone and of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rc_channel_normalizer;

  import rcn_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  // a centre request keeps the block busy while the divider runs and gives no result
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 160;
  localparam int NUM_PHASES     = 8;
  localparam int TIMEOUT_CYCLES = 800_000;
  localparam int MAX_PRINTS     = 40;

  // one sample result as seen on the result channel
  typedef struct packed {
    logic [15:0]        raw_width;
    logic signed [15:0] norm_value;
    logic               valid_res;
  } stick_t;

  // one row of the directed table; known marks a hand-typed expectation
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] width;
    logic        known;
    stick_t      result;
  } stim_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_op          = OP_SAMPLE;
  logic [15:0]           in_pulse_width = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [15:0]           out_raw_width;
  logic signed [15:0]    out_norm_value;
  logic                  out_valid_res;
  logic                  cfg_wr_en      = 1'b0;
  logic [DZ_BITS-1:0]    cfg_wr_data    = '0;

  // calibration state as the block should hold it
  logic [15:0]        cal_lower;
  logic [15:0]        cal_upper;
  logic [15:0]        cal_centre;
  logic [31:0]        cal_recip;
  logic [DZ_BITS-1:0] dz_setting;

  stick_t pending_sticks[$];
  int     mismatch_count   = 0;
  int     requests_sent    = 0;
  int     sender_idle_pct  = 0;
  int     receiver_stall_pct = 0;

  // Directed table. The block starts with unset bounds, so every width clamps
  // to zero and the value reads 0 until a centre has been captured.
  stim_row_t directed_rows [0:24] = '{
    '{OP_SAMPLE, 16'd0,     1'b1, '{16'd0,     16'sd0, 1'b0}}, // signal loss
    '{OP_SAMPLE, 16'd65535, 1'b1, '{16'd65535, 16'sd0, 1'b1}}, // widest
    '{OP_SAMPLE, 16'd1,     1'b1, '{16'd1,     16'sd0, 1'b1}}, // narrowest
    '{OP_CENTER, 16'd1500,  1'b0, '0},                         // centre, no bounds
    '{OP_SAMPLE, 16'd1500,  1'b0, '0},
    '{OP_BOUNDS, 16'd1000,  1'b0, '0},
    '{OP_BOUNDS, 16'd2000,  1'b0, '0},
    '{OP_BOUNDS, 16'd0,     1'b0, '0},                         // lower back to unset
    '{OP_BOUNDS, 16'd1000,  1'b0, '0},
    '{OP_CENTER, 16'd1500,  1'b0, '0},
    '{OP_SAMPLE, 16'd1000,  1'b0, '0},                         // full negative
    '{OP_SAMPLE, 16'd2000,  1'b0, '0},                         // full positive
    '{OP_SAMPLE, 16'd1510,  1'b0, '0},                         // inside deadzone
    '{OP_SAMPLE, 16'd500,   1'b0, '0},                         // clamped low
    '{OP_SAMPLE, 16'd65535, 1'b0, '0},                         // clamped high
    '{OP_SAMPLE, 16'd0,     1'b1, '{16'd1500,  16'sd0, 1'b0}}, // loss reports centre
    '{OP_BOUNDS, 16'd100,   1'b0, '0},                         // widen past the span
    '{OP_BOUNDS, 16'd60000, 1'b0, '0},
    '{OP_SAMPLE, 16'd100,   1'b0, '0},                         // negative saturation
    '{OP_SAMPLE, 16'd60000, 1'b0, '0},                         // positive saturation
    '{OP_CLEAR,  16'd65535, 1'b0, '0},
    '{OP_CENTER, 16'd0,     1'b0, '0},                         // zero offset, no scale
    '{OP_SAMPLE, 16'd40000, 1'b1, '{16'd40000, 16'sd0, 1'b1}},
    '{OP_CENTER, 16'd65535, 1'b0, '0},
    '{OP_SAMPLE, 16'd32768, 1'b0, '0}
  };

  rc_channel_normalizer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_pulse_width (in_pulse_width),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_raw_width  (out_raw_width),
    .out_norm_value (out_norm_value),
    .out_valid_res  (out_valid_res),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_rc_channel_normalizer: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Clamp, centre, scale, apply the deadzone and saturate one sample, or report a lost signal.
  function automatic stick_t normalise_sample(input logic [15:0] w);
    stick_t             r;
    logic [15:0]        c;
    logic signed [17:0] d;
    logic [16:0]        d_abs;
    logic [63:0]        mag;
    c = w;
    if (c < cal_lower) begin
      c = cal_lower;
    end else if (c > cal_upper) begin
      c = cal_upper;
    end
    d     = $signed({2'b00, c}) - $signed({2'b00, cal_centre});
    d_abs = (d < 0) ? 17'(-d) : 17'(d);
    mag   = (64'(d_abs) * 64'(cal_recip)) >> 16;
    r.raw_width = w;
    r.valid_res = 1'b1;
    if (w == 16'd0) begin
      // signal lost: report the centre and a neutral stick
      r.raw_width  = cal_centre;
      r.norm_value = '0;
      r.valid_res  = 1'b0;
    end else if (mag <= 64'(dz_setting)) begin
      r.norm_value = '0;
    end else begin
      mag = mag - 64'(dz_setting);
      if (d < 0) begin
        r.norm_value = (mag >= 64'd32768) ? 16'h8000 : 16'(64'd0 - mag);
      end else begin
        r.norm_value = (mag > 64'd32767) ? 16'h7FFF : 16'(mag);
      end
    end
    return r;
  endfunction

  // Advance the calibration state by one accepted non-sample request.
  task automatic update_calibration(input logic [1:0] op, input logic [15:0] w);
    logic signed [17:0] to_lower;
    logic signed [17:0] to_upper;
    logic signed [17:0] span;
    case (op)
      OP_BOUNDS: begin
        if (cal_upper == 16'd0 || w > cal_upper) cal_upper = w;
        if (cal_lower == 16'd0 || w < cal_lower) cal_lower = w;
      end
      OP_CENTER: begin
        cal_centre = w;
        to_lower   = $signed({2'b00, w}) - $signed({2'b00, cal_lower});
        to_upper   = $signed({2'b00, cal_upper}) - $signed({2'b00, w});
        span       = (to_lower > to_upper) ? to_lower : to_upper;
        if (span <= 0) begin
          cal_recip = '0;
        end else begin
          cal_recip = 32'((64'd1 << 31) / 64'(span));
        end
      end
      OP_CLEAR: begin
        cal_lower = '0;
        cal_upper = '0;
      end
      default: ;
    endcase
  endtask

  // Offer one request, hold it until accepted, then record what it implies.
  // Valid stays high on return so back-to-back requests need no toggle.
  task automatic send_request(input logic [1:0] op, input logic [15:0] w,
                              input logic known, input stick_t typed);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_pulse_width <= w;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (op == OP_SAMPLE) begin
      pending_sticks.push_back(known ? typed : normalise_sample(w));
    end else begin
      update_calibration(op, w);
    end
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sticks.size() != 0) @(posedge clk);
  endtask

  // Write the deadzone once the block is idle; allow a centre request to end.
  task automatic write_deadzone(input logic [DZ_BITS-1:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    dz_setting  = value;
  endtask

  function automatic logic [15:0] clip_width(input int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // Random traffic: mostly whole calibration sessions (clear, bounds, centre,
  // then a run of samples), the rest loose requests of any op and width.
  task automatic run_random(input int n_items);
    int     target;
    int     lo;
    int     hi;
    int     centre;
    int     n;
    int     pick;
    logic [15:0] w;
    target = requests_sent + n_items;
    while (requests_sent < target) begin
      if ($urandom_range(99) < 80) begin
        lo = $urandom_range(60000, 1);
        hi = lo + (($urandom_range(3) == 0) ? $urandom_range(5535, 1)
                                            : $urandom_range(1200, 200));
        send_request(OP_CLEAR, 16'($urandom), 1'b0, '0);
        send_request(OP_BOUNDS, 16'(lo), 1'b0, '0);
        send_request(OP_BOUNDS, 16'(hi), 1'b0, '0);
        n = $urandom_range(3);
        repeat (n) send_request(OP_BOUNDS, 16'($urandom_range(hi, lo)), 1'b0, '0);
        pick = $urandom_range(9);
        if (pick == 0) begin
          centre = lo;
        end else if (pick == 1) begin
          centre = $urandom_range(65535);
        end else begin
          centre = $urandom_range(hi, lo);
        end
        send_request(OP_CENTER, 16'(centre), 1'b0, '0);
        n = $urandom_range(24, 8);
        repeat (n) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            w = 16'd0;
          end else if (pick < 18) begin
            w = 16'($urandom);
          end else if (pick < 28) begin
            w = clip_width(($urandom_range(1) != 0) ? hi + $urandom_range(300, 1)
                                                    : lo - $urandom_range(300, 1));
          end else if (pick < 32) begin
            // widen the bounds after the centre: magnitudes go past full scale
            send_request(OP_BOUNDS,
                         clip_width(($urandom_range(1) != 0) ? hi + $urandom_range(2000)
                                                             : lo - $urandom_range(2000)),
                         1'b0, '0);
            w = clip_width(($urandom_range(1) != 0) ? hi + 2000 : lo - 2000);
          end else begin
            w = 16'($urandom_range(hi, lo));
          end
          send_request(OP_SAMPLE, w, 1'b0, '0);
        end
      end else begin
        n = $urandom_range(6, 1);
        repeat (n) begin
          w = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
          send_request(2'($urandom_range(3)), w, 1'b0, '0);
        end
      end
    end
  endtask

  // Receiver: stall at the rate the current phase asks.
  always @(posedge clk) begin
    out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  // Check every result taken against the oldest expectation.
  always @(posedge clk) begin
    stick_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sticks.size() == 0) begin
        report_mismatch($sformatf("unexpected result raw=%0d norm=%0d valid=%0b",
                                  out_raw_width, out_norm_value, out_valid_res));
      end else begin
        exp_r = pending_sticks.pop_front();
        if (out_raw_width !== exp_r.raw_width) begin
          report_mismatch($sformatf("raw_width %0d, expected %0d",
                                    out_raw_width, exp_r.raw_width));
        end
        if (out_norm_value !== exp_r.norm_value) begin
          report_mismatch($sformatf("norm_value %0d, expected %0d (raw %0d)",
                                    out_norm_value, exp_r.norm_value, exp_r.raw_width));
        end
        if (out_valid_res !== exp_r.valid_res) begin
          report_mismatch($sformatf("valid_res %0b, expected %0b (raw %0d)",
                                    out_valid_res, exp_r.valid_res, exp_r.raw_width));
        end
      end
    end
  end

  initial begin
    logic [DZ_BITS-1:0] dz_plan [0:NUM_PHASES-1];
    int                 guard;
    cal_lower  = '0;
    cal_upper  = '0;
    cal_centre = '0;
    cal_recip  = '0;
    dz_setting = DZ_RESET;

    // hold reset, then release it on a clock edge
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling, reset deadzone
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].width,
                   directed_rows[i].known, directed_rows[i].result);
    end

    // deadzone extremes, the reset value and random settings in between
    dz_plan[0] = '0;
    dz_plan[1] = 15'h7FFF;
    dz_plan[2] = 15'($urandom_range(32767));
    dz_plan[3] = 15'd1;
    dz_plan[4] = DZ_RESET;
    dz_plan[5] = 15'($urandom_range(3000));
    dz_plan[6] = 15'd16384;
    dz_plan[7] = 15'($urandom_range(32767));

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_deadzone(dz_plan[p]);
      // cycle through: no idling, sender gaps, receiver stalls, both
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
        default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
      endcase
      run_random(PHASE_ITEMS / 2);
      // pause the sender until the block has handed back everything
      hold_until_drained();
      run_random(PHASE_ITEMS / 2);
    end

    // drain, bounded, then let any trailing centre request finish
    in_valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending_sticks.size() != 0 && guard < 20000) begin
      guard++;
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_sticks.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_sticks.size()));
    end

    if (mismatch_count == 0) begin
      $display("tb_rc_channel_normalizer: PASS");
    end else begin
      $display("tb_rc_channel_normalizer: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rcn_pkg.sv
sv/rcn_ser_mul.sv
sv/rcn_ser_div.sv
sv/rc_channel_normalizer.sv
tb/sv/tb_rc_channel_normalizer.sv
